// ===== hdl/assert_macros.svh =====
// assertion macros shared by the fft engine modules
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define RFE_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define RFE_ASSERT(lbl, clk, rst_n, prop)
`define RFE_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/rfe_pkg.sv =====
// shared types, constants and twiddle generation for the fft engine
// no dependencies

package rfe_pkg;

	localparam int Points = 1024;
	localparam int Log2Points = 10;
	localparam int WordBits = 36;
	localparam int SampleWidth = 24;
	localparam int QueueDepth = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
	localparam int unsigned DivCos [16] = '{2, 12, 30, 56, 90, 132, 182, 240,
		306, 380, 462, 552, 650, 756, 870, 992};
	localparam int unsigned DivSin [16] = '{6, 20, 42, 72, 110, 156, 210, 272,
		342, 420, 506, 600, 702, 812, 930, 1056};

	typedef struct packed {
		logic operation;
		logic signed [SampleWidth-1:0] sample_real;
		logic signed [SampleWidth-1:0] sample_imag;
	} req_t;

	typedef struct packed {
		logic signed [WordBits-1:0] bin_real;
		logic signed [WordBits-1:0] bin_imag;
		logic [Log2Points-1:0] bin_index;
		logic last_bin;
	} res_t;

	// q2.62 product, bits 125:62, rescaled to q2.62
	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// returns {cos, sin} of pi/2 * j / (points/4), each rounded to f fraction bits
	function automatic logic [63:0] twiddle(input int unsigned j, input int unsigned lg,
		input int unsigned f);
		logic [63:0] frac, x, x2, tc, ts, sc, ss, c, s;
		frac = 64'(j) << (64 - lg);
		x = mulq(HalfPiQ62, frac);
		x2 = mulq(x, x);
		tc = 64'd1 << 62;
		ts = x;
		sc = tc;
		ss = x;
		for (int i = 1; i <= 16; i++) begin
			tc = mulq(tc / 64'(DivCos[i-1]), x2);
			ts = mulq(ts / 64'(DivSin[i-1]), x2);
			if (i % 2 == 1) begin
				sc = sc - tc;
				ss = ss - ts;
			end else begin
				sc = sc + tc;
				ss = ss + ts;
			end
		end
		c = (sc + (64'd1 << (61 - f))) >> (62 - f);
		s = (ss + (64'd1 << (61 - f))) >> (62 - f);
		return {c[31:0], s[31:0]};
	endfunction

endpackage

// ===== hdl/radix2_fft_ifft_engine.sv =====
// top level of the 1024 point radix-2 fft / ifft engine
// depends on rfe_pkg, rfe_front and rfe_back
//
// usage
//   request channel: a request is taken at a clock edge where start is high
//   and busy is low. operation load stores the next sample in natural order;
//   the load of the last sample of a frame starts the transform. operation
//   read returns the next bin; a read with no finished frame returns nothing.
//   requests go into a four entry queue, so busy only rises when it is full.
//   result channel: done is high for exactly one cycle with the bin on
//   result; the receiver cannot stall it.
//   config channel: cfg_ready is always high; cfg_data bit 0 selects the
//   inverse transform and is sampled when the last sample is loaded.
// flow
//   a read shows done through the rd_s1 and done_q registers after it leaves
//   the queue. the transform runs on one sample store with one read port and
//   one write port: bit reversal first, then the butterflies, during which
//   the queue fills and holds off.
// reset
//   clears the queue, counters, frame state and mode; sample store is not
//   cleared.

module radix2_fft_ifft_engine #(
	parameter int TWIDDLE_FRAC_BITS = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rfe_pkg::req_t request,
	output logic done,
	output rfe_pkg::res_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic inverse_q;
	logic avail, pop;
	rfe_pkg::req_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			inverse_q <= cfg_data;
		end
	end

	rfe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.avail(avail),
		.head(head),
		.pop(pop)
	);

	rfe_back #(
		.FRAC_BITS(TWIDDLE_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.inverse_mode(inverse_q),
		.avail(avail),
		.head(head),
		.pop(pop),
		.done(done),
		.result(result)
	);

endmodule

// ===== hdl/rfe_front.sv =====
// request intake and queue of the fft engine
// depends on rfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module rfe_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rfe_pkg::req_t request,
	output logic avail,
	output rfe_pkg::req_t head,
	input  logic pop
);

	localparam int Depth = rfe_pkg::QueueDepth;
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	rfe_pkg::req_t fifo_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;

	assign busy = count_q == CntW'(Depth);
	assign push = start && !busy;
	assign avail = count_q != '0;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`RFE_ASSERT(a_pop_nonempty, clk, arst_n, pop |-> count_q != '0)
	`RFE_ASSERT(a_push_grows, clk, arst_n, (push && !pop) |=> count_q == $past(count_q) + CntW'(1))
	`RFE_NEVER(a_count_range, clk, arst_n, count_q > CntW'(Depth))

endmodule

// ===== hdl/rfe_back.sv =====
// sample store, bit reversal, butterfly sequencer and bin readout
// depends on rfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module rfe_back #(
	parameter int FRAC_BITS = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic inverse_mode,
	input  logic avail,
	input  rfe_pkg::req_t head,
	output logic pop,
	output logic done,
	output rfe_pkg::res_t result
);

	localparam int L = rfe_pkg::Log2Points;
	localparam int W = rfe_pkg::WordBits;
	localparam int P = rfe_pkg::Points;
	localparam int Quarter = P / 4;
	localparam int StW = $clog2(L);
	localparam int TwW = FRAC_BITS + 2;
	localparam int PW = W + TwW;
	localparam logic signed [PW-1:0] RndHalf = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [W:0] ScaleHalf = (W + 1)'(1) << (L - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BR_RD1, ST_BR_RD2, ST_BR_WR1, ST_BR_WR2,
		ST_BF_RD1, ST_BF_RD2, ST_BF_MUL, ST_BF_ADD, ST_BF_WR1, ST_BF_WR2
	} state_t;

	state_t state_q;
	logic [2*W-1:0] mem [P];
	logic [2*W-1:0] rdata_q, ua_q, wd;
	logic [L-1:0] ra, wa;
	logic we;

	logic [L-1:0] load_cnt_q, read_cnt_q, i_q, rev_i;
	logic [L-2:0] m_q;
	logic [StW-1:0] s_q;
	logic frame_ready_q, inv_q, rd_s1, done_q;
	logic [L-1:0] idx_s1;
	logic last_s1;
	rfe_pkg::res_t result_q;

	logic [L-1:0] m_ext, a_addr, b_addr, mask;
	logic [L-2:0] tw_t, tw_j;
	logic tw_neg, neg_q;
	logic [2*(FRAC_BITS+1)-1:0] rom [Quarter+1];
	logic [2*(FRAC_BITS+1)-1:0] tw_q;
	logic signed [TwW-1:0] wr, wi;
	logic signed [W-1:0] xr, xi, tr_q, ti_q;
	logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [W-1:0] out_re, out_im, neg_im;
	logic signed [W:0] sc_re, sc_im;

	for (genvar g = 0; g <= Quarter; g++) begin : g_rom
		localparam logic [63:0] Tw = rfe_pkg::twiddle(g, L, FRAC_BITS);
		assign rom[g] = {Tw[32+FRAC_BITS:32], Tw[FRAC_BITS:0]};
	end

	always_comb begin
		rev_i = '0;
		for (int b = 0; b < L; b++) begin
			rev_i[L-1-b] = i_q[b];
		end
	end

	assign mask = ~({L{1'b1}} << s_q);
	assign m_ext = {1'b0, m_q};
	assign a_addr = ((m_ext >> s_q) << (s_q + StW'(1))) | (m_ext & mask);
	assign b_addr = a_addr | (L'(1) << s_q);
	assign tw_t = (L-1)'(m_ext & mask) << (StW'(L - 1) - s_q);
	assign tw_neg = tw_t > (L-1)'(Quarter);
	assign tw_j = tw_neg ? (L-1)'(P / 2) - tw_t : tw_t;

	function automatic logic [W-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		q = p + RndHalf;
		q = q >>> FRAC_BITS;
		return q[W-1:0];
	endfunction

	function automatic logic [2*W-1:0] conj(input logic [2*W-1:0] v, input logic en);
		return en ? {v[2*W-1:W], W'(-v[W-1:0])} : v;
	endfunction

	assign pop = state_q == ST_IDLE && avail;

	always_comb begin
		we = 1'b0;
		wa = a_addr;
		wd = '0;
		ra = a_addr;
		unique case (state_q)
			ST_IDLE: begin
				ra = read_cnt_q;
				wa = load_cnt_q;
				we = pop && head.operation == rfe_pkg::OP_LOAD;
				wd = {W'(head.sample_real), W'(head.sample_imag)};
			end
			ST_BR_RD1: ra = i_q;
			ST_BR_RD2: ra = rev_i;
			ST_BR_WR1: begin
				we = 1'b1;
				wa = i_q;
				wd = conj(rdata_q, inv_q);
			end
			ST_BR_WR2: begin
				we = 1'b1;
				wa = rev_i;
				wd = conj(ua_q, inv_q);
			end
			ST_BF_RD2: ra = b_addr;
			ST_BF_WR1: begin
				we = 1'b1;
				wd = {ua_q[2*W-1:W] + tr_q, ua_q[W-1:0] + ti_q};
			end
			ST_BF_WR2: begin
				we = 1'b1;
				wa = b_addr;
				wd = {ua_q[2*W-1:W] - tr_q, ua_q[W-1:0] - ti_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	assign wr = neg_q ? -TwW'(tw_q[2*FRAC_BITS+1:FRAC_BITS+1])
		: TwW'(tw_q[2*FRAC_BITS+1:FRAC_BITS+1]);
	assign wi = -TwW'(tw_q[FRAC_BITS:0]);
	assign xr = rdata_q[2*W-1:W];
	assign xi = rdata_q[W-1:0];

	always_ff @(posedge clk) begin
		tw_q <= rom[tw_j];
		neg_q <= tw_neg;
		if (state_q == ST_BR_RD2 || state_q == ST_BF_RD2) begin
			ua_q <= rdata_q;
		end
		p_rr_q <= PW'(wr) * PW'(xr);
		p_ii_q <= PW'(wi) * PW'(xi);
		p_ri_q <= PW'(wr) * PW'(xi);
		p_ir_q <= PW'(wi) * PW'(xr);
		if (state_q == ST_BF_ADD) begin
			tr_q <= rnd(p_rr_q) - rnd(p_ii_q);
			ti_q <= rnd(p_ri_q) + rnd(p_ir_q);
		end
	end

	assign neg_im = -xi;
	assign sc_re = ($signed({xr[W-1], xr}) + ScaleHalf) >>> L;
	assign sc_im = ($signed({neg_im[W-1], neg_im}) + ScaleHalf) >>> L;
	assign out_re = inv_q ? sc_re[W-1:0] : xr;
	assign out_im = inv_q ? sc_im[W-1:0] : xi;

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			result_q.bin_real <= out_re;
			result_q.bin_imag <= out_im;
			result_q.bin_index <= idx_s1;
			result_q.last_bin <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_cnt_q <= '0;
			read_cnt_q <= '0;
			frame_ready_q <= 1'b0;
			inv_q <= 1'b0;
			i_q <= '0;
			m_q <= '0;
			s_q <= '0;
			rd_s1 <= 1'b0;
			idx_s1 <= '0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rd_s1 <= 1'b0;
			done_q <= rd_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.operation == rfe_pkg::OP_LOAD) begin
							frame_ready_q <= 1'b0;
							read_cnt_q <= '0;
							load_cnt_q <= load_cnt_q + L'(1);
							if (load_cnt_q == L'(P - 1)) begin
								inv_q <= inverse_mode;
								i_q <= '0;
								state_q <= ST_BR_RD1;
							end
						end else if (frame_ready_q) begin
							rd_s1 <= 1'b1;
							idx_s1 <= read_cnt_q;
							last_s1 <= read_cnt_q == L'(P - 1);
							read_cnt_q <= read_cnt_q + L'(1);
							if (read_cnt_q == L'(P - 1)) begin
								frame_ready_q <= 1'b0;
							end
						end
					end
				end
				ST_BR_RD1: begin
					if (i_q <= rev_i) begin
						state_q <= ST_BR_RD2;
					end else if (i_q == L'(P - 1)) begin
						m_q <= '0;
						s_q <= '0;
						state_q <= ST_BF_RD1;
					end else begin
						i_q <= i_q + L'(1);
					end
				end
				ST_BR_RD2: state_q <= ST_BR_WR1;
				ST_BR_WR1: state_q <= ST_BR_WR2;
				ST_BR_WR2: begin
					if (i_q == L'(P - 1)) begin
						m_q <= '0;
						s_q <= '0;
						state_q <= ST_BF_RD1;
					end else begin
						i_q <= i_q + L'(1);
						state_q <= ST_BR_RD1;
					end
				end
				ST_BF_RD1: state_q <= ST_BF_RD2;
				ST_BF_RD2: state_q <= ST_BF_MUL;
				ST_BF_MUL: state_q <= ST_BF_ADD;
				ST_BF_ADD: state_q <= ST_BF_WR1;
				ST_BF_WR1: state_q <= ST_BF_WR2;
				ST_BF_WR2: begin
					m_q <= m_q + (L-1)'(1);
					state_q <= ST_BF_RD1;
					if (m_q == {(L-1){1'b1}}) begin
						s_q <= s_q + StW'(1);
						if (s_q == StW'(L - 1)) begin
							frame_ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

	`RFE_ASSERT(a_read_strobe, clk, arst_n, rd_s1 |=> done_q)
	`RFE_ASSERT(a_pop_idle, clk, arst_n, pop |-> state_q == ST_IDLE)
	`RFE_NEVER(a_ready_busy, clk, arst_n, frame_ready_q && state_q != ST_IDLE)

endmodule
